>>> sv/chm_pkg.sv
package chm_pkg;

	localparam int BUCKETS    = 64;
	localparam int ENTRIES    = 256;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int PTR_W  = $clog2(ENTRIES + 1);
	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CNT_W  = $clog2(BUCKETS + 1);
	localparam int CFG_W  = 7;
	localparam int MAG_W  = KEY_BITS + (KEY_BITS % 2);
	localparam int STEPS  = MAG_W / 2;
	localparam int STEP_W = $clog2(STEPS + 1);

	localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(ENTRIES);
	localparam logic [CFG_W-1:0] BC_RESET = CFG_W'(64);

	typedef enum logic [1:0] {
		OP_GET    = 2'd0,
		OP_PUT    = 2'd1,
		OP_SUBMIT = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_HEAD,
		ST_HEAD2,
		ST_WALK,
		ST_CMP,
		ST_ALLOC_RD,
		ST_ALLOC,
		ST_HIT_PUT,
		ST_UNLINK,
		ST_RELEASE,
		ST_DONE
	} state_t;

	function automatic logic ptr_nil(input logic [PTR_W-1:0] p);
		return p >= NIL_PTR;
	endfunction

endpackage

>>> sv/chm_ram.sv
module chm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/chm_mod.sv
module chm_mod
	import chm_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [KEY_BITS-1:0] key,
	input  logic [CNT_W-1:0]           bc,
	output logic                       done,
	output logic [BKT_W-1:0]           bucket
);

	localparam int RW = CNT_W + 2;

	logic              busy_q, done_q, neg_q;
	logic [STEP_W-1:0] cnt_q;
	logic [MAG_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q, bc_q, rem_d;
	logic [RW-1:0]     t, bc1, bc2, bc3;
	logic [KEY_BITS-1:0] mag_in;

	assign mag_in = key[KEY_BITS-1] ? (~key + 1'b1) : key;

	// radix-4 restoring step: subtract the largest multiple of bc that fits
	always_comb begin
		t   = {rem_q, mag_q[MAG_W-1 -: 2]};
		bc1 = RW'(bc_q);
		bc2 = bc1 << 1;
		bc3 = bc1 + bc2;
		if (t >= bc3) begin
			rem_d = CNT_W'(t - bc3);
		end else if (t >= bc2) begin
			rem_d = CNT_W'(t - bc2);
		end else if (t >= bc1) begin
			rem_d = CNT_W'(t - bc1);
		end else begin
			rem_d = CNT_W'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(STEPS);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= MAG_W'(mag_in);
			neg_q <= key[KEY_BITS-1];
			bc_q  <= bc;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			mag_q <= mag_q << 2;
			rem_q <= rem_d;
		end
	end

	// negative key: remainder of the magnitude folded to non-negative
	assign done   = done_q;
	assign bucket = (neg_q && rem_q != '0) ? BKT_W'(bc_q - rem_q) : BKT_W'(rem_q);

endmodule

>>> sv/chained_hash_map_engine.sv
// Separate-chaining hash table over a fixed pool of ENTRIES nodes.
// Request channel: in_valid/in_ready with operation (get, put, submit if
// absent, pop), signed key and value. One result per request on
// out_valid/out_ready: found, prior_value, status (1 = pool full on insert)
// and entry_count after the request.
// cfg_we/cfg_wdata write the bucket count; write only while idle.
// Per request: the key remainder (launch, 16 radix-4 steps of 2 key bits,
// done flag, bucket capture), the bucket head read, the chain check, a
// node memory read and a compare per chain node visited, write-back on
// insert or pop (a single value write on a put hit), and a register for
// the result. Each node ahead in the chain lengthens a request.
// One request is in flight at a time; in_ready returns in the same cycle
// that the result appears in the output register.
// Reset: bucket heads read empty and the free list links every node in
// order (per-entry valid bits, no clearing pass), count zero, bucket
// count 64. If the receiver stalls, a finished result waits in the final
// state until the output register frees.
module chained_hash_map_engine
	import chm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic signed [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0]        value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [VALUE_BITS-1:0]        prior_value,
	output logic                         status,
	output logic [PTR_W-1:0]             entry_count,
	input  logic                         cfg_we,
	input  logic [CFG_W-1:0]             cfg_wdata
);

	state_t st_q, st_d;

	logic [CFG_W-1:0]      bc_q;
	logic [CNT_W-1:0]      bc_eff;
	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q, old_q;
	logic [BKT_W-1:0]      b_q;
	logic [PTR_W-1:0]      head_q, cur_q, prev_q, hit_q, nhit_q, free_q, live_q;
	logic                  found_q, status_q;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [BUCKETS-1:0]    hv_q;
	logic [ENTRIES-1:0]    nv_q;
	logic                  start_q;

	logic                  out_valid_q, found_o_q, status_o_q;
	logic [VALUE_BITS-1:0] old_o_q;
	logic [PTR_W-1:0]      count_o_q;

	logic                  mod_start, mod_done;
	logic [BKT_W-1:0]      mod_bucket;

	logic                  head_we;
	logic [PTR_W-1:0]      head_wdata, head_dout, head_rd;
	logic                  key_we, val_we, next_we;
	logic [IDX_W-1:0]      node_waddr, next_waddr, node_raddr;
	logic [VALUE_BITS-1:0] val_wdata, val_dout;
	logic [KEY_BITS-1:0]   key_dout;
	logic [PTR_W-1:0]      next_wdata, next_dout, next_rd;
	logic                  accept, out_free, is_insert;

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign is_insert = (op_q == OP_PUT) || (op_q == OP_SUBMIT);

	// divider starts the cycle after the request is captured
	assign mod_start = start_q;

	always_comb begin
		if (bc_q == '0) begin
			bc_eff = CNT_W'(1);
		end else if (bc_q > CFG_W'(BUCKETS)) begin
			bc_eff = CNT_W'(BUCKETS);
		end else begin
			bc_eff = CNT_W'(bc_q);
		end
	end

	chm_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (key_q),
		.bc     (bc_eff),
		.done   (mod_done),
		.bucket (mod_bucket)
	);

	chm_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_head (
		.clk   (clk),
		.we    (head_we),
		.waddr (b_q),
		.wdata (head_wdata),
		.raddr (b_q),
		.rdata (head_dout)
	);

	chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (node_waddr),
		.wdata (key_q),
		.raddr (node_raddr),
		.rdata (key_dout)
	);

	chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val (
		.clk   (clk),
		.we    (val_we),
		.waddr (node_waddr),
		.wdata (val_wdata),
		.raddr (node_raddr),
		.rdata (val_dout)
	);

	chm_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_next (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.raddr (node_raddr),
		.rdata (next_dout)
	);

	// never-written entries read as their reset contents
	assign head_rd = hv_q[b_q] ? head_dout : NIL_PTR;
	assign next_rd = nv_q[rd_idx_s1] ? next_dout : ({1'b0, rd_idx_s1} + 1'b1);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:     if (accept) st_d = ST_DIV;
			ST_DIV:      if (mod_done) st_d = ST_HEAD;
			ST_HEAD:     st_d = ST_HEAD2;
			ST_HEAD2:    st_d = ST_WALK;
			ST_WALK: begin
				if (!ptr_nil(cur_q)) begin
					st_d = ST_CMP;
				end else if (is_insert && !ptr_nil(free_q)) begin
					st_d = ST_ALLOC_RD;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_CMP: begin
				if (key_dout != key_q) begin
					st_d = ST_WALK;
				end else if (op_q == OP_PUT) begin
					st_d = ST_HIT_PUT;
				end else if (op_q == OP_POP) begin
					st_d = ST_UNLINK;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_ALLOC_RD: st_d = ST_ALLOC;
			ST_ALLOC:    st_d = ST_DONE;
			ST_HIT_PUT:  st_d = ST_DONE;
			ST_UNLINK:   st_d = ST_RELEASE;
			ST_RELEASE:  st_d = ST_DONE;
			ST_DONE:     if (out_free) st_d = ST_IDLE;
			default:     st_d = ST_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready   = 1'b0;
		head_we    = 1'b0;
		head_wdata = nhit_q;
		key_we     = 1'b0;
		val_we     = 1'b0;
		val_wdata  = val_q;
		node_waddr = free_q[IDX_W-1:0];
		next_we    = 1'b0;
		next_waddr = prev_q[IDX_W-1:0];
		next_wdata = nhit_q;
		node_raddr = cur_q[IDX_W-1:0];
		case (st_q)
			ST_IDLE: in_ready = 1'b1;
			ST_ALLOC_RD: node_raddr = free_q[IDX_W-1:0];
			ST_ALLOC: begin
				key_we     = 1'b1;
				val_we     = 1'b1;
				next_we    = 1'b1;
				next_waddr = free_q[IDX_W-1:0];
				next_wdata = head_q;
				head_we    = 1'b1;
				head_wdata = free_q;
			end
			ST_HIT_PUT: begin
				val_we     = 1'b1;
				node_waddr = hit_q[IDX_W-1:0];
			end
			ST_UNLINK: begin
				if (ptr_nil(prev_q)) begin
					head_we = 1'b1;
				end else begin
					next_we = 1'b1;
				end
			end
			ST_RELEASE: begin
				next_we    = 1'b1;
				next_waddr = hit_q[IDX_W-1:0];
				next_wdata = free_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			bc_q        <= BC_RESET;
			hv_q        <= '0;
			nv_q        <= '0;
			free_q      <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
			start_q     <= 1'b0;
		end else begin
			st_q    <= st_d;
			start_q <= accept;
			if (cfg_we) begin
				bc_q <= cfg_wdata;
			end
			if (head_we) begin
				hv_q[b_q] <= 1'b1;
			end
			if (next_we) begin
				nv_q[next_waddr] <= 1'b1;
			end
			if (st_q == ST_ALLOC) begin
				free_q <= next_rd;
				live_q <= live_q + 1'b1;
			end
			if (st_q == ST_RELEASE) begin
				free_q <= hit_q;
				if (live_q != '0) begin
					live_q <= live_q - 1'b1;
				end
			end
			if (st_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= node_raddr;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= op_t'(operation);
					key_q    <= key;
					val_q    <= value;
					old_q    <= '0;
					found_q  <= 1'b0;
					status_q <= 1'b0;
				end
			end
			ST_DIV: begin
				if (mod_done) begin
					b_q <= mod_bucket;
				end
			end
			ST_HEAD2: begin
				head_q <= head_rd;
				cur_q  <= head_rd;
				prev_q <= NIL_PTR;
			end
			ST_WALK: begin
				if (ptr_nil(cur_q) && is_insert && ptr_nil(free_q)) begin
					status_q <= 1'b1;
				end
			end
			ST_CMP: begin
				if (key_dout == key_q) begin
					found_q <= 1'b1;
					old_q   <= val_dout;
					hit_q   <= cur_q;
					nhit_q  <= next_rd;
				end else begin
					prev_q <= cur_q;
					cur_q  <= next_rd;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					found_o_q  <= found_q;
					old_o_q    <= old_q;
					status_o_q <= status_q;
					count_o_q  <= live_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign found       = found_o_q;
	assign prior_value = old_o_q;
	assign status      = status_o_q;
	assign entry_count = count_o_q;

endmodule
